### sv/rpsc_pkg.sv
// ----------------------------------------------------------------------------
// rpsc_pkg
// Shared field width and field type for the range paint and segment count block.
// ----------------------------------------------------------------------------
package rpsc_pkg;

    localparam int FIELD_W = 11;

    typedef logic [FIELD_W-1:0] t_field;

endpackage

### sv/rpsc_item_if.sv
// ----------------------------------------------------------------------------
// rpsc_item_if
// Input channel: one range paint request per item.
// ----------------------------------------------------------------------------
interface rpsc_item_if;

    logic              valid;
    logic              ready;
    rpsc_pkg::t_field  range_first;
    rpsc_pkg::t_field  range_last;
    logic              paint_set;

    modport source (output valid, output range_first, output range_last,
                    output paint_set, input ready);
    modport sink   (input valid, input range_first, input range_last,
                    input paint_set, output ready);

endinterface

### sv/rpsc_result_if.sv
// ----------------------------------------------------------------------------
// rpsc_result_if
// Output channel: total count of set cells per item.
// ----------------------------------------------------------------------------
interface rpsc_result_if;

    logic              valid;
    logic              ready;
    rpsc_pkg::t_field  set_total;

    modport source (output valid, output set_total, input ready);
    modport sink   (input valid, input set_total, output ready);

endinterface

### sv/rpsc_ram.sv
// ----------------------------------------------------------------------------
// rpsc_ram
// Generic RAM, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rpsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### sv/range_paint_segment_count.sv
// ----------------------------------------------------------------------------
// range_paint_segment_count
// Range set/clear over a row of 2^LOG_SIZE cells, returns total set count.
// ----------------------------------------------------------------------------
// Cost: each active tree node takes a read state and a write state on the
//   single node RAM.
// Throughput: one item at a time; the next item can be accepted in the cycle
//   after the previous result is loaded into the output register.
// Reset: synchronous; afterwards a clearing pass over all 2^LOG_SIZE node
//   addresses zeroes the node RAM before the first item is accepted.
// ----------------------------------------------------------------------------
module range_paint_segment_count #(
    parameter int LOG_SIZE = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rpsc_item_if.sink     i_item,
    rpsc_result_if.source o_result
);

    localparam int SIZE = 1 << LOG_SIZE;
    localparam int CNW  = LOG_SIZE + 1;
    localparam int EW   = 2 * CNW;
    localparam int DW   = $clog2(LOG_SIZE + 1);
    localparam int XW   = (LOG_SIZE + 1 > rpsc_pkg::FIELD_W) ? LOG_SIZE + 1
                                                             : rpsc_pkg::FIELD_W;

    typedef enum logic [8:0] {
        S_CLR     = 9'b000000001,
        S_IDLE    = 9'b000000010,
        S_ROOT    = 9'b000000100,
        S_DN_RD   = 9'b000001000,
        S_DN_WR   = 9'b000010000,
        S_UP_RD   = 9'b000100000,
        S_UP_WR   = 9'b001000000,
        S_ROOT_WR = 9'b010000000,
        S_OUT     = 9'b100000000
    } t_state;

    function automatic logic [LOG_SIZE-1:0] f_mask(input logic [DW-1:0] d);
        f_mask = ~({LOG_SIZE{1'b1}} >> d);
    endfunction

    function automatic logic [LOG_SIZE-1:0] f_node(input logic [DW-1:0] d,
                                                   input logic [LOG_SIZE-1:0] x);
        logic [LOG_SIZE-1:0] one;
        one    = LOG_SIZE'(1) << d;
        f_node = one | (x >> (LOG_SIZE - int'(d)));
    endfunction

    function automatic logic f_part(input logic [DW-1:0] d,
                                    input logic [LOG_SIZE-1:0] x,
                                    input logic [LOG_SIZE-1:0] a0,
                                    input logic [LOG_SIZE-1:0] b0);
        logic [LOG_SIZE-1:0] m;
        logic [LOG_SIZE-1:0] lo;
        logic [LOG_SIZE-1:0] hi;
        m      = f_mask(d);
        lo     = x & m;
        hi     = x | ~m;
        f_part = (int'(d) < LOG_SIZE) && !((a0 <= lo) && (hi <= b0));
    endfunction

    t_state                r_state, n_state;
    logic [LOG_SIZE-1:0]   r_a0, n_a0;
    logic [LOG_SIZE-1:0]   r_b0, n_b0;
    logic                  r_val, n_val;
    logic                  r_empty, n_empty;
    logic [DW-1:0]         r_dep, n_dep;
    logic                  r_slot, n_slot;
    logic [CNW-1:0]        r_cnt0, n_cnt0;
    logic [CNW-1:0]        r_cnt1, n_cnt1;
    logic [CNW-1:0]        r_sum0, n_sum0;
    logic [CNW-1:0]        r_sum1, n_sum1;
    logic [LOG_SIZE-1:0]   r_clr, n_clr;
    logic                  r_ovalid, n_ovalid;
    rpsc_pkg::t_field      r_total, n_total;

    logic                  ram_we;
    logic [LOG_SIZE-1:0]   ram_waddr;
    logic [EW-1:0]         ram_wdata;
    logic [LOG_SIZE-1:0]   ram_raddr;
    logic [EW-1:0]         ram_rdata;

    logic [XW-1:0]         first_x, last_x;
    logic [DW-1:0]         dep1;
    logic [LOG_SIZE-1:0]   x_cur, mask, lo, hi, cmask, chi0, clo1, hbit;
    logic [LOG_SIZE-1:0]   node_a, node_b, node_cur;
    logic                  shared, act, sa, sb, cov0, cov1, pa_c, pb_c;
    logic                  rep_a, rep_b, load_out;
    logic [CNW-1:0]        half, span, fill, cnt_cur, old0, old1;
    logic [CNW-1:0]        new0, new1, u0, u1, usum;

    rpsc_ram #(
        .WIDTH (EW),
        .DEPTH (SIZE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // node geometry for the current depth and path
    always_comb begin
        dep1     = r_dep + DW'(1);
        x_cur    = r_slot ? r_b0 : r_a0;
        mask     = f_mask(r_dep);
        lo       = x_cur & mask;
        hi       = x_cur | ~mask;
        cmask    = f_mask(dep1);
        hbit     = LOG_SIZE'(1) << (LOG_SIZE - 1 - int'(r_dep));
        chi0     = lo | ~cmask;
        clo1     = lo | hbit;
        node_a   = f_node(r_dep, r_a0);
        node_b   = f_node(r_dep, r_b0);
        shared   = (node_a == node_b);
        node_cur = r_slot ? node_b : node_a;
        act      = f_part(r_dep, x_cur, r_a0, r_b0) && (!r_slot || !shared);
        half     = CNW'(1) << (LOG_SIZE - 1 - int'(r_dep));
        span     = half << 1;
        fill     = r_val ? half : '0;
        sa       = |(r_a0 & hbit);
        sb       = |(r_b0 & hbit);
        cov0     = (r_a0 <= lo) && (chi0 <= r_b0);
        cov1     = (r_a0 <= clo1) && (hi <= r_b0);
        old0     = ram_rdata[CNW-1:0];
        old1     = ram_rdata[EW-1:CNW];
        cnt_cur  = r_slot ? r_cnt1 : r_cnt0;

        // push a uniform parent down, then assign fully covered children
        if (cov0) begin
            new0 = fill;
        end else if (cnt_cur == '0) begin
            new0 = '0;
        end else if (cnt_cur == span) begin
            new0 = half;
        end else begin
            new0 = old0;
        end
        if (cov1) begin
            new1 = fill;
        end else if (cnt_cur == '0) begin
            new1 = '0;
        end else if (cnt_cur == span) begin
            new1 = half;
        end else begin
            new1 = old1;
        end

        // substitute the recomputed counts of partial children
        pa_c  = f_part(dep1, r_a0, r_a0, r_b0);
        pb_c  = f_part(dep1, r_b0, r_a0, r_b0);
        rep_a = !r_slot && pa_c;
        rep_b = pb_c && (r_slot || shared);
        if (rep_a && !sa) begin
            u0 = r_sum0;
        end else if (rep_b && !sb) begin
            u0 = r_sum1;
        end else begin
            u0 = old0;
        end
        if (rep_a && sa) begin
            u1 = r_sum0;
        end else if (rep_b && sb) begin
            u1 = r_sum1;
        end else begin
            u1 = old1;
        end
        usum = u0 + u1;
    end

    always_comb begin
        first_x = XW'(i_item.range_first);
        last_x  = XW'(i_item.range_last);
        if (first_x == '0) begin
            first_x = XW'(1);
        end
        if (last_x > XW'(SIZE)) begin
            last_x = XW'(SIZE);
        end
    end

    assign load_out = (r_state == S_OUT) && (!r_ovalid || o_result.ready);

    always_comb begin
        n_state   = r_state;
        n_a0      = r_a0;
        n_b0      = r_b0;
        n_val     = r_val;
        n_empty   = r_empty;
        n_dep     = r_dep;
        n_slot    = r_slot;
        n_cnt0    = r_cnt0;
        n_cnt1    = r_cnt1;
        n_sum0    = r_sum0;
        n_sum1    = r_sum1;
        n_clr     = r_clr;
        n_total   = r_total;
        n_ovalid  = r_ovalid;
        ram_we    = 1'b0;
        ram_waddr = node_cur;
        ram_wdata = {new1, new0};
        ram_raddr = '0;

        if (o_result.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + LOG_SIZE'(1);
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_item.valid) begin
                    n_a0    = LOG_SIZE'(first_x - XW'(1));
                    n_b0    = LOG_SIZE'(last_x - XW'(1));
                    n_val   = i_item.paint_set;
                    n_empty = (first_x > last_x);
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                n_dep  = '0;
                n_slot = 1'b1;
                n_cnt0 = old0;
                n_cnt1 = old0;
                if (r_empty) begin
                    n_sum0  = old0;
                    n_state = S_ROOT_WR;
                end else if (!f_part('0, r_a0, r_a0, r_b0)) begin
                    n_sum0  = r_val ? CNW'(SIZE) : '0;
                    n_state = S_ROOT_WR;
                end else begin
                    n_state = S_DN_RD;
                end
            end
            S_DN_RD, S_DN_WR: begin
                ram_raddr = node_cur;
                if (r_state == S_DN_RD && act) begin
                    n_state = S_DN_WR;
                end else begin
                    if (r_state == S_DN_WR) begin
                        ram_we = 1'b1;
                        if (r_slot) begin
                            n_cnt1 = sb ? new1 : new0;
                        end else begin
                            n_cnt0 = sa ? new1 : new0;
                            if (shared) begin
                                n_cnt1 = sb ? new1 : new0;
                            end
                        end
                    end
                    // advance: slot 1 then slot 0, depth downwards
                    if (r_slot) begin
                        n_slot  = 1'b0;
                        n_state = S_DN_RD;
                    end else begin
                        n_slot  = 1'b1;
                        if (int'(r_dep) == LOG_SIZE - 1) begin
                            n_state = S_UP_RD;
                        end else begin
                            n_dep   = dep1;
                            n_state = S_DN_RD;
                        end
                    end
                end
            end
            S_UP_RD, S_UP_WR: begin
                ram_raddr = node_cur;
                ram_wdata = {u1, u0};
                if (r_state == S_UP_RD && act) begin
                    n_state = S_UP_WR;
                end else begin
                    if (r_state == S_UP_WR) begin
                        ram_we = 1'b1;
                        if (r_slot) begin
                            n_sum1 = usum;
                        end else begin
                            n_sum0 = usum;
                            if (shared) begin
                                n_sum1 = usum;
                            end
                        end
                    end
                    // advance: slot 1 then slot 0, depth upwards
                    if (r_slot) begin
                        n_slot  = 1'b0;
                        n_state = S_UP_RD;
                    end else begin
                        n_slot = 1'b1;
                        if (r_dep == '0) begin
                            n_state = S_ROOT_WR;
                        end else begin
                            n_dep   = r_dep - DW'(1);
                            n_state = S_UP_RD;
                        end
                    end
                end
            end
            S_ROOT_WR: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = {CNW'(0), r_sum0};
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (load_out) begin
                    n_total  = rpsc_pkg::FIELD_W'(r_sum0);
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a0    <= n_a0;
        r_b0    <= n_b0;
        r_val   <= n_val;
        r_empty <= n_empty;
        r_dep   <= n_dep;
        r_slot  <= n_slot;
        r_cnt0  <= n_cnt0;
        r_cnt1  <= n_cnt1;
        r_sum0  <= n_sum0;
        r_sum1  <= n_sum1;
        r_total <= n_total;
    end

    assign i_item.ready       = (r_state == S_IDLE);
    assign o_result.valid     = r_ovalid;
    assign o_result.set_total = r_total;

endmodule
